// ----- rtl/hsl_to_rgb_top_assert.svh -----
`ifndef HSL_TO_RGB_TOP_ASSERT_SVH
`define HSL_TO_RGB_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HSL_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hsl_to_rgb: assertion failed");

// Next-cycle implication, checked outside reset.
`define HSL_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hsl_to_rgb: assertion failed");

`endif

// ----- rtl/hsl_pkg.sv -----
package hsl_pkg;

  localparam int HUE_W  = 13;
  localparam int FRAC_W = 11;
  localparam int CHAN_W = 8;
  localparam int K_W    = 10;
  localparam int P_W    = 21;
  localparam int NUM_W  = 30;
  localparam int Z_W    = 12;
  localparam int STAGES = 6;
  localparam int CHANS  = 3;

  localparam logic [HUE_W-1:0]  HUE_TURN       = 13'd5760;
  localparam logic [HUE_W-1:0]  HUE_THIRD      = 13'd1920;
  localparam logic [HUE_W-1:0]  HUE_SIXTH      = 13'd960;
  localparam logic [HUE_W-1:0]  HUE_HALF       = 13'd2880;
  localparam logic [HUE_W-1:0]  HUE_TWO_THIRDS = 13'd3840;
  localparam logic [FRAC_W-1:0] FRAC_ONE       = 11'd1024;
  localparam logic [FRAC_W-1:0] FRAC_HALF      = 11'd512;
  localparam logic [K_W-1:0]    K_MAX          = 10'd960;
  localparam logic [P_W-1:0]    ONE20          = 21'h100000;
  localparam logic [Z_W-1:0]    Z_MAX          = 12'd3832;
  localparam logic [CHAN_W-1:0] CHAN_MAX       = 8'd255;

  // ramp weight in sixths of a turn: rising, flat high, falling, flat low
  function automatic logic [K_W-1:0] hue_weight(input logic [HUE_W-1:0] t);
    logic [HUE_W-1:0] fall;
    fall = HUE_TWO_THIRDS - t;
    if (t < HUE_SIXTH) begin
      return t[K_W-1:0];
    end else if (t < HUE_HALF) begin
      return K_MAX;
    end else if (t < HUE_TWO_THIRDS) begin
      return fall[K_W-1:0];
    end else begin
      return '0;
    end
  endfunction

endpackage

// ----- rtl/hsl_to_rgb_top.sv -----
// HSL to 8-bit RGB converter. Takes one word per clock and returns one word per
// clock unless out_stall holds the pipe, through six register stages (clamp and
// hue offsets, l*s multiply, q/p, ramp multiply, scale by 255, reciprocal
// divide). A stall holds only full stages, so bubbles close up, and while a
// finished result waits at the output a new word is taken if a stage is empty.
module hsl_to_rgb_top
  import hsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  hue,
  input  logic [FRAC_W-1:0] saturation,
  input  logic [FRAC_W-1:0] lightness,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] red,
  output logic [CHAN_W-1:0] green,
  output logic [CHAN_W-1:0] blue
);

`include "hsl_to_rgb_top_assert.svh"

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;

  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1: wrap hue, clamp fractions, per-channel hue offsets
  logic [HUE_W-1:0]  h_w;
  logic [HUE_W-1:0]  t_r;
  logic [HUE_W-1:0]  t_b;
  logic [FRAC_W-1:0] s_c;
  logic [FRAC_W-1:0] l_c;
  logic [HUE_W-1:0]  t1 [CHANS];
  logic [FRAC_W-1:0] s1;
  logic [FRAC_W-1:0] l1;

  always_comb begin
    h_w = (hue >= HUE_TURN) ? hue - HUE_TURN : hue;
    t_r = h_w + HUE_THIRD;
    if (t_r >= HUE_TURN) t_r = t_r - HUE_TURN;
    t_b = (h_w >= HUE_THIRD) ? h_w - HUE_THIRD : h_w + HUE_TURN - HUE_THIRD;
    s_c = (saturation > FRAC_ONE) ? FRAC_ONE : saturation;
    l_c = (lightness > FRAC_ONE) ? FRAC_ONE : lightness;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      t1[0] <= t_r;
      t1[1] <= h_w;
      t1[2] <= t_b;
      s1    <= s_c;
      l1    <= l_c;
    end
  end

  // stage 2: l*s and ramp weights
  logic [P_W-1:0]    ls2;
  logic [K_W-1:0]    k2 [CHANS];
  logic [FRAC_W-1:0] s2;
  logic [FRAC_W-1:0] l2;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ls2 <= P_W'(l1) * P_W'(s1);
      for (int c = 0; c < CHANS; c++) k2[c] <= hue_weight(t1[c]);
      s2 <= s1;
      l2 <= l1;
    end
  end

  // stage 3: q, p and d = q - p in units of 2^-20
  logic [P_W+1:0] q_x;
  logic [P_W+1:0] p_x;
  logic [P_W+1:0] d_x;
  logic [P_W-1:0] p3;
  logic [P_W-1:0] d3;
  logic [K_W-1:0] k3 [CHANS];

  always_comb begin
    if (l2 < FRAC_HALF) begin
      q_x = {l2, 10'd0} + (P_W+2)'(ls2);
    end else begin
      q_x = {l2, 10'd0} + {s2, 10'd0} - (P_W+2)'(ls2);
    end
    p_x = {1'b0, l2, 11'd0} - q_x;
    d_x = q_x - p_x;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p3 <= p_x[P_W-1:0];
      d3 <= d_x[P_W-1:0];
      for (int c = 0; c < CHANS; c++) k3[c] <= k2[c];
    end
  end

  // stage 4: num = p*960 + d*k
  logic [NUM_W-1:0] num4 [CHANS];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int c = 0; c < CHANS; c++) begin
        num4[c] <= NUM_W'(p3) * NUM_W'(K_MAX) + NUM_W'(d3) * NUM_W'(k3[c]);
      end
    end
  end

  // stage 5: scale by 255, add half, drop 2^26 (2^20 * 64)
  localparam int X_W = NUM_W + 8;
  logic [X_W-1:0] x5 [CHANS];
  logic [Z_W-1:0] z5 [CHANS];

  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      x5[c] = (X_W'(num4[c]) << 8) - X_W'(num4[c]) + (X_W'(480) << 20);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < CHANS; c++) z5[c] <= x5[c][X_W-1:X_W-Z_W];
    end
  end

  // stage 6: divide by 15 via 4370/2^16, exact for z below 4681
  logic [Z_W+12:0]   prod6 [CHANS];
  logic [CHAN_W-1:0] res6  [CHANS];

  always_comb begin
    for (int c = 0; c < CHANS; c++) begin
      prod6[c] = (Z_W+13)'(z5[c]) * (Z_W+13)'(4370);
      res6[c]  = prod6[c][Z_W+12:24] != '0 ? CHAN_MAX : prod6[c][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      red   <= res6[0];
      green <= res6[1];
      blue  <= res6[2];
    end
  end

  `HSL_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && !in_stall, vld[0])
  `HSL_ASSERT_NOW(a_weight_range, clk, rst, vld[2],
                  k3[0] <= K_MAX && k3[1] <= K_MAX && k3[2] <= K_MAX)
  `HSL_ASSERT_NOW(a_qp_range, clk, rst, vld[2],
                  p3 <= ONE20 && d3 <= ONE20 && (p3 + d3) <= ONE20)
  `HSL_ASSERT_NOW(a_quot_range, clk, rst, vld[4],
                  z5[0] <= Z_MAX && z5[1] <= Z_MAX && z5[2] <= Z_MAX)

endmodule

// ----- test/testbench.sv -----
module testbench
  import hsl_pkg::*;
();

  localparam int unsigned TURN      = 5760;
  localparam int unsigned THIRD     = 1920;
  localparam int unsigned SIXTH     = 960;
  localparam int unsigned HALF_TURN = 2880;
  localparam int unsigned TWO_THIRD = 3840;
  localparam int unsigned UNIT      = 1024;
  localparam int unsigned MID       = 512;
  localparam int unsigned FULL      = 255;

  typedef struct {
    logic [HUE_W-1:0]  h;
    logic [FRAC_W-1:0] s;
    logic [FRAC_W-1:0] l;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } pixel_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [HUE_W-1:0]  hue        = '0;
  logic [FRAC_W-1:0] saturation = '0;
  logic [FRAC_W-1:0] lightness  = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  pixel_t rgb_expected[$];
  int     mismatches   = 0;
  bit     gaps_on      = 1'b0;
  int     hold_request = 0;
  int     hold_left    = 0;

  hsl_to_rgb_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CHAN_W-1:0] channel_level(input longint unsigned p20,
                                                      input longint unsigned q20,
                                                      input int unsigned t);
    longint unsigned den;
    longint unsigned num;
    longint unsigned level;
    den = 64'(SIXTH) << 20;
    if (t < SIXTH) begin
      num = p20 * SIXTH + (q20 - p20) * t;
    end else if (t < HALF_TURN) begin
      num = q20 * SIXTH;
    end else if (t < TWO_THIRD) begin
      num = p20 * SIXTH + (q20 - p20) * (TWO_THIRD - t);
    end else begin
      num = p20 * SIXTH;
    end
    level = (64'd2 * num * FULL + den) / (64'd2 * den);
    if (level > FULL) level = FULL;
    return level[CHAN_W-1:0];
  endfunction

  function automatic pixel_t color_from_hsl(input logic [HUE_W-1:0] h_in,
                                            input logic [FRAC_W-1:0] s_in,
                                            input logic [FRAC_W-1:0] l_in);
    pixel_t          px;
    int unsigned     h;
    int unsigned     t_red;
    int unsigned     t_blue;
    longint unsigned s;
    longint unsigned l;
    longint unsigned q20;
    longint unsigned p20;
    px.h = h_in;
    px.s = s_in;
    px.l = l_in;
    h = 32'(h_in);
    if (h >= TURN) h = h - TURN;
    s = (s_in > UNIT) ? 64'(UNIT) : 64'(s_in);
    l = (l_in > UNIT) ? 64'(UNIT) : 64'(l_in);
    if (l < MID) begin
      q20 = l * (UNIT + s);
    end else begin
      q20 = (l + s) * UNIT - l * s;
    end
    p20 = 2 * l * UNIT - q20;
    t_red = h + THIRD;
    if (t_red >= TURN) t_red = t_red - TURN;
    t_blue = (h >= THIRD) ? (h - THIRD) : (h + TURN - THIRD);
    px.r = channel_level(p20, q20, t_red);
    px.g = channel_level(p20, q20, h);
    px.b = channel_level(p20, q20, t_blue);
    return px;
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned roll;
    int unsigned edges[10] = '{0, 959, 960, 1919, 1920, 2879, 2880, 3839, 3840, 5759};
    roll = $urandom_range(99);
    if (roll < 80) return HUE_W'($urandom_range(5759));
    if (roll < 90) return HUE_W'(edges[$urandom_range(9)]);
    return HUE_W'($urandom_range(8191));
  endfunction

  function automatic logic [FRAC_W-1:0] pick_frac();
    int unsigned roll;
    int unsigned edges[7] = '{0, 1, 511, 512, 513, 1023, 1024};
    roll = $urandom_range(99);
    if (roll < 70) return FRAC_W'($urandom_range(1024));
    if (roll < 85) return FRAC_W'(edges[$urandom_range(6)]);
    return FRAC_W'($urandom_range(2047));
  endfunction

  task automatic send_word(input logic [HUE_W-1:0] h, input logic [FRAC_W-1:0] s,
                           input logic [FRAC_W-1:0] l);
    while (gaps_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    lightness  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rgb_expected = {rgb_expected, color_from_hsl(h, s, l)};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_word(pick_hue(), pick_frac(), pick_frac());
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    send_word(0, 1024, 512);
    send_word(1920, 1024, 512);
    send_word(3840, 1024, 512);
    send_word(5759, 1024, 512);
    send_word(959, 1024, 512);
    send_word(960, 1024, 512);
    send_word(2879, 1024, 512);
    send_word(2880, 1024, 512);
    send_word(3839, 1024, 512);
    send_word(4800, 1024, 512);
    send_word(0, 0, 0);
    send_word(0, 0, 1024);
    send_word(2000, 0, 700);
    send_word(1000, 1024, 511);
    send_word(1000, 1024, 512);
    send_word(1000, 512, 1);
    send_word(4000, 1, 1023);
    send_word(0, 1024, 1024);
    send_word(100, 1024, 0);
    // hue past a full turn, fractions past 1.0
    send_word(5760, 1024, 512);
    send_word(8191, 2047, 2047);
    send_word(6000, 1025, 1025);
    send_word(300, 2047, 300);
    send_word(7000, 700, 2047);
    drain_results();
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    send_random(250);
    drain_results();
  endtask

  task automatic test_random_gaps();
    gaps_on = 1'b1;
    send_random(900);
    drain_results();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b1;
    hold_request = 300;
    send_random(80);
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rgb_expected.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: rgb %0d %0d %0d", red, green, blue);
        mismatches++;
      end else begin
        want = rgb_expected.pop_front();
        if (red !== want.r || green !== want.g || blue !== want.b) begin
          if (mismatches < 10) begin
            $display("mismatch hsl %0d %0d %0d: exp rgb %0d %0d %0d, got %0d %0d %0d",
                     want.h, want.s, want.l, want.r, want.g, want.b, red, green, blue);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_steady_stream();
    test_random_gaps();
    test_backpressure();
    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- hsl_to_rgb_top.f -----
+incdir+rtl
rtl/hsl_pkg.sv
rtl/hsl_to_rgb_top.sv
test/testbench.sv
